FILE: src/tlr_pkg.sv
`timescale 1ns / 1ps

package tlr_pkg;

   // Coordinate and colour widths are fixed by the 64 x 64 grid.
   localparam int unsigned COORD_W  = 6;
   localparam int unsigned COLOUR_W = 24;
   localparam int unsigned SPAN_W   = COORD_W + 1;
   localparam int unsigned ERR_W    = COORD_W + 2;

   typedef struct packed {
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      logic                thick;
      logic [COLOUR_W-1:0] colour;
   } req_word_type;

   typedef struct packed {
      logic [COORD_W-1:0]  pixel_x;
      logic [COORD_W-1:0]  pixel_y;
      logic [COORD_W-1:0]  extra_x;
      logic [COORD_W-1:0]  extra_y;
      logic                extra_valid;
      logic [COLOUR_W-1:0] pixel_colour;
      logic                last_pixel;
   } rsp_word_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

endpackage

FILE: src/thick_line_rasterizer_core.sv
`timescale 1ns / 1ps

// Thick line rasteriser core.
// req channel: one word per line segment (two endpoints, thick flag, colour).
// rsp channel: one word per pixel in Bresenham order from start to end; the
//   word at the end point carries last_pixel. With thick set, each word also
//   carries the companion pixel one step down (mostly horizontal lines) or
//   one step right (mostly vertical); extra_valid clears when that pixel is
//   off the FRAME_SIZE frame.
// A segment of n = max(|dx|,|dy|) + 1 pixels has one setup step, then one
//   Bresenham step per cycle while the receiver does not stall, through the
//   single error update/compare unit.
// After the req word is taken, the stepper enters S_RUN and then registers the first pixel word.
// req_stall is high while a segment is being stepped; the next segment is
//   taken as soon as the last pixel is in the output register, even if that
//   word is still waiting for the receiver.
// rsp_stall freezes the output register and with it the stepping unit.
// Reset (synchronous) returns to idle and drops rsp_valid.
module thick_line_rasterizer_core #(
   parameter int unsigned FRAME_SIZE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tlr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tlr_pkg::rsp_word_type rsp_word
);

   localparam int unsigned COORD_W = tlr_pkg::COORD_W;
   localparam int unsigned SPAN_W  = tlr_pkg::SPAN_W;
   localparam int unsigned ERR_W   = tlr_pkg::ERR_W;
   // compare width: shifted coordinate (COORD_W+1 bits) against the frame size
   localparam int unsigned FRAME_W = $clog2(FRAME_SIZE + 1);
   localparam int unsigned CMP_W   = (FRAME_W > COORD_W + 1) ? FRAME_W : COORD_W + 1;
   localparam logic [CMP_W-1:0] FRAME_LIM = CMP_W'(FRAME_SIZE);

   // control
   tlr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // segment context, loaded at accept
   logic [COORD_W-1:0]          cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]          cur_y_ff, cur_y_in;
   logic signed [ERR_W-1:0]     err_ff, err_in;
   logic [SPAN_W-1:0]           span_x_ff, span_x_in;
   logic signed [SPAN_W-1:0]    span_y_neg_ff, span_y_neg_in;
   logic                        step_x_neg_ff, step_x_neg_in;
   logic                        step_y_neg_ff, step_y_neg_in;
   logic [COORD_W-1:0]          target_x_ff, target_x_in;
   logic [COORD_W-1:0]          target_y_ff, target_y_in;
   logic                        shift_down_ff, shift_down_in;
   logic                        thick_ff, thick_in;
   logic [tlr_pkg::COLOUR_W-1:0] colour_ff, colour_in;
   tlr_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   // setup terms
   logic                 req_take;
   logic [COORD_W-1:0]   mag_x, mag_y;
   logic signed [SPAN_W-1:0] dy_neg;

   // stepping unit
   logic                     rsp_free;
   logic                     at_target;
   logic signed [ERR_W:0]    e2;
   logic signed [ERR_W:0]    dx_ext, dy_ext;
   logic                     move_x, move_y;
   logic signed [ERR_W:0]    err_sum;
   logic [COORD_W:0]         ex_wide, ey_wide;
   logic                     extra_ok;

   assign req_stall = (state_ff != tlr_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign at_target = (cur_x_ff == target_x_ff) && (cur_y_ff == target_y_ff);

   // absolute spans of the incoming segment
   always_comb begin
      mag_x  = (req_word.end_x > req_word.start_x) ? req_word.end_x - req_word.start_x
                                                   : req_word.start_x - req_word.end_x;
      mag_y  = (req_word.end_y > req_word.start_y) ? req_word.end_y - req_word.start_y
                                                   : req_word.start_y - req_word.end_y;
      dy_neg = SPAN_W'(0) - SPAN_W'(mag_y);
   end

   // one Bresenham step: double the error, compare against both spans, update
   always_comb begin
      e2      = {err_ff[ERR_W-1], err_ff} <<< 1;
      dx_ext  = (ERR_W+1)'(span_x_ff);
      dy_ext  = {{(ERR_W+1-SPAN_W){span_y_neg_ff[SPAN_W-1]}}, span_y_neg_ff};
      move_x  = (e2 >= dy_ext);
      move_y  = (e2 <= dx_ext);
      err_sum = {err_ff[ERR_W-1], err_ff}
              + (move_x ? dy_ext : '0)
              + (move_y ? dx_ext : '0);
   end

   // companion pixel and frame check
   always_comb begin
      ex_wide  = shift_down_ff ? {1'b0, cur_x_ff} : {1'b0, cur_x_ff} + 1'b1;
      ey_wide  = shift_down_ff ? {1'b0, cur_y_ff} + 1'b1 : {1'b0, cur_y_ff};
      extra_ok = thick_ff && (CMP_W'(ex_wide) < FRAME_LIM) && (CMP_W'(ey_wide) < FRAME_LIM);
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      err_in        = err_ff;
      span_x_in     = span_x_ff;
      span_y_neg_in = span_y_neg_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      shift_down_in = shift_down_ff;
      thick_in      = thick_ff;
      colour_in     = colour_ff;
      rsp_word_in   = rsp_word_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tlr_pkg::S_IDLE: begin
            if (req_take) begin
               cur_x_in      = req_word.start_x;
               cur_y_in      = req_word.start_y;
               span_x_in     = SPAN_W'(mag_x);
               span_y_neg_in = dy_neg;
               err_in        = ERR_W'(SPAN_W'(mag_x)) + {dy_neg[SPAN_W-1], dy_neg};
               step_x_neg_in = !(req_word.start_x < req_word.end_x);
               step_y_neg_in = !(req_word.start_y < req_word.end_y);
               target_x_in   = req_word.end_x;
               target_y_in   = req_word.end_y;
               shift_down_in = (mag_x >= mag_y);
               thick_in      = req_word.thick;
               colour_in     = req_word.colour;
               state_in      = tlr_pkg::S_RUN;
            end
         end
         tlr_pkg::S_RUN: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.pixel_x      = cur_x_ff;
               rsp_word_in.pixel_y      = cur_y_ff;
               rsp_word_in.extra_x      = extra_ok ? ex_wide[COORD_W-1:0] : '0;
               rsp_word_in.extra_y      = extra_ok ? ey_wide[COORD_W-1:0] : '0;
               rsp_word_in.extra_valid  = extra_ok;
               rsp_word_in.pixel_colour = colour_ff;
               rsp_word_in.last_pixel   = at_target;
               if (at_target) begin
                  state_in = tlr_pkg::S_IDLE;
               end else begin
                  err_in = ERR_W'(err_sum);
                  if (move_x) begin
                     cur_x_in = step_x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
                  end
                  if (move_y) begin
                     cur_y_in = step_y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = tlr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      err_ff        <= err_in;
      span_x_ff     <= span_x_in;
      span_y_neg_ff <= span_y_neg_in;
      step_x_neg_ff <= step_x_neg_in;
      step_y_neg_ff <= step_y_neg_in;
      target_x_ff   <= target_x_in;
      target_y_ff   <= target_y_in;
      shift_down_ff <= shift_down_in;
      thick_ff      <= thick_in;
      colour_ff     <= colour_in;
      rsp_word_ff   <= rsp_word_in;
   end

`ifndef NO_ASSERTIONS
   // a taken segment always starts the stepper
   a_take_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == tlr_pkg::S_RUN))
      else $error("segment taken but stepper not running");

   // reaching the end point emits a last word and frees the input
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlr_pkg::S_RUN) && rsp_free && at_target
      |=> (state_ff == tlr_pkg::S_IDLE) && rsp_valid && rsp_word.last_pixel)
      else $error("end point did not close the segment");

   // a dropped companion pixel carries zero coordinates
   a_extra_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.extra_valid |-> (rsp_word.extra_x == '0) && (rsp_word.extra_y == '0))
      else $error("invalid companion pixel has non-zero coordinates");
`endif

endmodule
